[rtl/brf_pkg.sv]
`default_nettype none
package brf_pkg;

	localparam int BYTE_W = 8;
	localparam int ARG_W  = 10;
	localparam int CNT_W  = 10;
	localparam int CFG_W  = 11;
	localparam int CMD_W  = 3;

	localparam logic [CFG_W-1:0] RING_SIZE_RST = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_SKIP   = 3'd3,
		CMD_FLUSH  = 3'd4,
		CMD_CONTIG = 3'd5,
		CMD_STATUS = 3'd6
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] wr_byte;
		logic [ARG_W-1:0]  count_or_offset;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rd_byte;
		logic              ok;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  fill_count;
		logic [CNT_W-1:0]  free_space;
		logic              is_empty;
		logic              is_full;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic exec;
		logic post;
	} ctrl_t;

endpackage
`default_nettype wire

[rtl/brf_ram.sv]
`default_nettype none
module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/brf_ctrl.sv]
`default_nettype none
module brf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	output brf_pkg::ctrl_t      ctrl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EXEC,
		ST_POST
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_POST);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CALC;
						busy_q  <= 1'b1;
					end
				end
				ST_CALC: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign ctrl = '{
		load: start && !busy_q,
		calc: (state_q == ST_CALC),
		exec: (state_q == ST_EXEC),
		post: (state_q == ST_POST)
	};

endmodule
`default_nettype wire

[rtl/brf_dp.sv]
`default_nettype none
module brf_dp #(
	parameter int DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire brf_pkg::ctrl_t               ctrl,
	input  wire brf_pkg::req_t                req,
	input  wire logic                         cfg_we,
	input  wire logic [brf_pkg::CFG_W-1:0]    cfg_wdata,
	output brf_pkg::rsp_t                     rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int LW = (SW > brf_pkg::CFG_W) ? SW : brf_pkg::CFG_W;

	function automatic logic [LW-1:0] clamp_f(input logic [brf_pkg::CFG_W-1:0] v);
		logic [LW-1:0] x;
		x = LW'(v);
		if (x < LW'(2)) begin
			x = LW'(2);
		end
		if (x > LW'(DEPTH)) begin
			x = LW'(DEPTH);
		end
		return x;
	endfunction

	logic [LW-1:0]              s_q;
	logic [AW-1:0]              rp_q;
	logic [AW-1:0]              wp_q;
	brf_pkg::cmd_t              cmd_q;
	logic [brf_pkg::BYTE_W-1:0] wb_q;
	logic [brf_pkg::ARG_W-1:0]  arg_q;
	logic [LW-1:0]              fill_q;
	logic                       full_q;
	logic [AW-1:0]              addr_q;
	logic                       ok_q;
	logic [brf_pkg::CNT_W-1:0]  cnt_q;
	logic                       take_q;
	brf_pkg::rsp_t              rsp_q;

	logic [LW-1:0]              rpx;
	logic [LW-1:0]              wpx;
	logic [LW-1:0]              argx;
	logic [LW-1:0]              fill;
	logic [LW-1:0]              wp_inc;
	logic [LW-1:0]              rp_inc;
	logic                       full;
	logic [LW:0]                sum;
	logic [LW:0]                start_pt;
	logic                       hit;
	logic [LW-1:0]              skip_n;
	logic [LW:0]                skip_sum;
	logic [LW:0]                skip_pt;
	logic [LW-1:0]              run;
	logic [LW-1:0]              rem;
	logic [LW-1:0]              free;

	logic                       ram_we;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [brf_pkg::BYTE_W-1:0] ram_rdata;

	assign rpx    = LW'(rp_q);
	assign wpx    = LW'(wp_q);
	assign argx   = LW'(arg_q);
	assign fill   = (wpx >= rpx) ? (wpx - rpx) : (s_q - (rpx - wpx));
	assign wp_inc = (wpx + LW'(1) == s_q) ? '0 : (wpx + LW'(1));
	assign rp_inc = (rpx + LW'(1) == s_q) ? '0 : (rpx + LW'(1));
	assign full   = (wp_inc == rpx);
	assign free   = s_q - LW'(1) - fill;

	// offset position wraps at most once when the offset is inside the fill
	assign sum      = {1'b0, rpx} + {1'b0, argx};
	assign start_pt = (sum >= {1'b0, s_q}) ? (sum - {1'b0, s_q}) : sum;

	assign hit      = (argx < fill_q);
	assign skip_n   = (argx > fill_q) ? fill_q : argx;
	assign skip_sum = {1'b0, rpx} + {1'b0, skip_n};
	assign skip_pt  = (skip_sum >= {1'b0, s_q}) ? (skip_sum - {1'b0, s_q}) : skip_sum;
	assign run      = s_q - LW'(addr_q);
	assign rem      = fill_q - argx;

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = rp_q;
		if (ctrl.exec) begin
			case (cmd_q)
				brf_pkg::CMD_PUSH: begin
					ram_we = !full_q;
				end
				brf_pkg::CMD_POP: begin
					ram_re = (fill_q != '0);
				end
				brf_pkg::CMD_PEEK: begin
					ram_re    = hit;
					ram_raddr = addr_q;
				end
				default: begin
					ram_re = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q  <= clamp_f(brf_pkg::RING_SIZE_RST);
			rp_q <= '0;
			wp_q <= '0;
		end else if (cfg_we) begin
			s_q  <= clamp_f(cfg_wdata);
			rp_q <= '0;
			wp_q <= '0;
		end else if (ctrl.exec) begin
			case (cmd_q)
				brf_pkg::CMD_PUSH: begin
					if (!full_q) begin
						wp_q <= AW'(wp_inc);
					end
				end
				brf_pkg::CMD_POP: begin
					if (fill_q != '0) begin
						rp_q <= AW'(rp_inc);
					end
				end
				brf_pkg::CMD_SKIP: begin
					rp_q <= AW'(skip_pt);
				end
				brf_pkg::CMD_FLUSH: begin
					rp_q <= wp_q;
				end
				default: begin
					rp_q <= rp_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= brf_pkg::cmd_t'(req.cmd);
			wb_q  <= req.wr_byte;
			arg_q <= req.count_or_offset;
		end
		if (ctrl.calc) begin
			fill_q <= fill;
			full_q <= full;
			addr_q <= AW'(start_pt);
		end
		if (ctrl.exec) begin
			case (cmd_q)
				brf_pkg::CMD_PUSH: begin
					ok_q   <= !full_q;
					cnt_q  <= '0;
					take_q <= 1'b0;
				end
				brf_pkg::CMD_POP: begin
					ok_q   <= (fill_q != '0);
					cnt_q  <= '0;
					take_q <= (fill_q != '0);
				end
				brf_pkg::CMD_PEEK: begin
					ok_q   <= hit;
					cnt_q  <= '0;
					take_q <= hit;
				end
				brf_pkg::CMD_SKIP: begin
					ok_q   <= 1'b1;
					cnt_q  <= brf_pkg::CNT_W'(skip_n);
					take_q <= 1'b0;
				end
				brf_pkg::CMD_CONTIG: begin
					ok_q   <= 1'b1;
					cnt_q  <= hit ? brf_pkg::CNT_W'((run < rem) ? run : rem) : '0;
					take_q <= 1'b0;
				end
				default: begin
					ok_q   <= 1'b1;
					cnt_q  <= '0;
					take_q <= 1'b0;
				end
			endcase
		end
		if (ctrl.post) begin
			rsp_q.rd_byte    <= take_q ? ram_rdata : '0;
			rsp_q.ok         <= ok_q;
			rsp_q.count      <= cnt_q;
			rsp_q.fill_count <= brf_pkg::CNT_W'(fill);
			rsp_q.free_space <= brf_pkg::CNT_W'(free);
			rsp_q.is_empty   <= (rp_q == wp_q);
			rsp_q.is_full    <= full;
		end
	end

	brf_ram #(
		.WIDTH (brf_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (wb_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp = rsp_q;

endmodule
`default_nettype wire

[rtl/byte_ring_fifo_with_peek.sv]
// sequence: a command taken while idle passes through the calc, execute and
// result states; its result shows on rsp with done high for one cycle, and
// busy is high while the command is in those three states
// ordering: a new command waits until busy is low, after the calc, execute
// and result steps around the registered read of the ring memory
// reset: arst_n clears both pointers and sets the ring size to 1024 slots,
// or DEPTH if less; memory stays undefined until written; results cannot stall
`default_nettype none
module byte_ring_fifo_with_peek #(
	parameter int DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire brf_pkg::req_t             req,
	output logic                           done,
	output brf_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_we,
	input  wire logic [brf_pkg::CFG_W-1:0] cfg_wdata
);

	brf_pkg::ctrl_t ctrl;

	brf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	brf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
